### src/kmt_pkg.sv
`timescale 1ns / 1ps

package kmt_pkg;

   // Fixed field widths of the request and result beats.
   localparam int KEY_WIDTH   = 16;
   localparam int FUNC_WIDTH  = 2;
   localparam int STAT_WIDTH  = 3;
   localparam int SLOT_WIDTH  = 4;
   localparam int COUNT_WIDTH = 5;

   // Operation codes.
   localparam logic [FUNC_WIDTH-1:0] FUNC_CREATE  = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DESTROY = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_LOCK    = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNLOCK  = 2'd3;

   // Status codes.
   localparam logic [STAT_WIDTH-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_WIDTH-1:0] ST_INVALID   = 3'd1;
   localparam logic [STAT_WIDTH-1:0] ST_EXISTS    = 3'd2;
   localparam logic [STAT_WIDTH-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_WIDTH-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STAT_WIDTH-1:0] ST_BUSY      = 3'd5;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [KEY_WIDTH-1:0]  key;
   } kmt_req_type;

   typedef struct packed {
      logic [STAT_WIDTH-1:0]  status;
      logic [SLOT_WIDTH-1:0]  slot;
      logic [COUNT_WIDTH-1:0] used_count;
   } kmt_rsp_type;

   // Commands from the sequencer to the key store.
   typedef struct packed {
      logic clear_find;
      logic rd_en;
      logic wr_set;
      logic wr_clr;
   } kmt_cmd_type;

   // Outcome of a scan over the key store.
   typedef struct packed {
      logic hit_found;
      logic free_found;
   } kmt_find_type;

endpackage

### src/keyed_mutex_table.sv
`timescale 1ns / 1ps

// Keyed mutex table. Software creates a mutex under a nonzero key, locks and
// unlocks it, and destroys it; every request beat returns exactly one result
// beat with a status, the slot involved and the number of slots in use. A
// lock never waits: it takes a free mutex or answers busy, and software
// retries. A request is taken when start is high and busy is low. A request
// with a nonzero key scans every slot through one shared key compare, one
// slot per cycle out of the key memory, and then executes; a request with a
// zero key skips the scan and goes straight to the execute step. The
// result beat is shown on rsp_data for exactly one cycle with rsp_valid
// high, and the receiver cannot hold it off, so it must take the beat in
// that cycle. Busy drops in the cycle the result appears, so the next
// request may be taken while the previous result is on the ports. Reset
// clears every slot at once through per-slot valid bits; no clearing pass
// follows reset. Key bits above KEY_BITS are ignored, and the slot and
// count fields carry the low bits of the internal slot index and count.
module keyed_mutex_table #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  kmt_pkg::kmt_req_type req_data,
   output logic                 rsp_valid,
   output kmt_pkg::kmt_rsp_type rsp_data
);

   // Stored key width: keys are never wider than the request field.
   localparam int KW = (KEY_BITS < kmt_pkg::KEY_WIDTH) ? KEY_BITS : kmt_pkg::KEY_WIDTH;
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic [kmt_pkg::FUNC_WIDTH-1:0]    func_ff;
   logic [KW-1:0]                     key_ff;
   logic                              zero_ff;
   logic [CW-1:0]                     used_ff, used_in;
   logic [SLOTS-1:0]                  taken_ff, taken_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   kmt_pkg::kmt_rsp_type              rsp_ff, rsp_in;

   kmt_pkg::kmt_cmd_type              cmd;
   kmt_pkg::kmt_find_type             find;
   logic [IW-1:0]                     hit_idx;
   logic [IW-1:0]                     free_idx;
   logic [IW-1:0]                     wr_addr;
   logic                              accept;
   logic [KW-1:0]                     req_key;
   logic [kmt_pkg::STAT_WIDTH-1:0]    exec_status;
   logic [IW-1:0]                     exec_slot;
   logic [IW+kmt_pkg::SLOT_WIDTH-1:0] exec_slot_wide;
   logic [CW+kmt_pkg::COUNT_WIDTH-1:0] used_wide;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign req_key = req_data.key[KW-1:0];

   // The request beat is held for the whole scan.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_data.func;
         key_ff  <= req_key;
         zero_ff <= (req_key == '0);
      end
   end

   kmt_key_store #(
      .SLOTS (SLOTS),
      .KW    (KW),
      .IW    (IW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (idx_ff),
      .wr_addr  (wr_addr),
      .key      (key_ff),
      .find     (find),
      .hit_idx  (hit_idx),
      .free_idx (free_idx)
   );

   // A create writes into the first free slot; every other operation acts on
   // the slot that matched.
   assign wr_addr = (func_ff == kmt_pkg::FUNC_CREATE) ? free_idx : hit_idx;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      taken_in     = taken_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd          = '0;
      exec_status  = kmt_pkg::ST_OK;
      exec_slot    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.clear_find = 1'b1;
               idx_in         = '0;
               state_in       = (req_key == '0) ? S_EXEC : S_SCAN;
            end
         end
         S_SCAN: begin
            // One slot read per cycle; the compare follows in the next cycle.
            cmd.rd_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // The last slot is compared in this cycle.
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (zero_ff) begin
               exec_status = kmt_pkg::ST_INVALID;
            end else if (func_ff == kmt_pkg::FUNC_CREATE) begin
               if (find.hit_found) begin
                  exec_status = kmt_pkg::ST_EXISTS;
                  exec_slot   = hit_idx;
               end else if (!find.free_found) begin
                  exec_status = kmt_pkg::ST_FULL;
               end else begin
                  cmd.wr_set         = 1'b1;
                  taken_in[free_idx] = 1'b0;
                  used_in            = used_ff + 1'b1;
                  exec_slot          = free_idx;
               end
            end else if (!find.hit_found) begin
               exec_status = kmt_pkg::ST_NOT_FOUND;
            end else begin
               exec_slot = hit_idx;
               unique case (func_ff)
                  kmt_pkg::FUNC_DESTROY: begin
                     cmd.wr_clr        = 1'b1;
                     taken_in[hit_idx] = 1'b0;
                     if (used_ff != '0) begin
                        used_in = used_ff - 1'b1;
                     end
                  end
                  kmt_pkg::FUNC_LOCK: begin
                     if (taken_ff[hit_idx]) begin
                        exec_status = kmt_pkg::ST_BUSY;
                     end else begin
                        taken_in[hit_idx] = 1'b1;
                     end
                  end
                  kmt_pkg::FUNC_UNLOCK: begin
                     taken_in[hit_idx] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            rsp_valid_in = 1'b1;
            rsp_in.status = exec_status;
            rsp_in.slot   = exec_slot_wide[kmt_pkg::SLOT_WIDTH-1:0];
            rsp_in.used_count = used_wide[kmt_pkg::COUNT_WIDTH-1:0];
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result fields carry the low bits of the slot index and of the count.
   assign exec_slot_wide = {{kmt_pkg::SLOT_WIDTH{1'b0}}, exec_slot};
   assign used_wide      = {{kmt_pkg::COUNT_WIDTH{1'b0}}, used_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         used_ff      <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result beat only ever follows the execute step.
   a_rsp_after_exec : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_EXEC)
      else $error("result beat without an execute step");

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");

   // The use count can never exceed the number of slots.
   a_used_bound : assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(SLOTS))
      else $error("use count above slot count");

   // A scan that finds no free slot means every slot is counted as used.
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !zero_ff && func_ff == kmt_pkg::FUNC_CREATE
       && !find.hit_found && !find.free_found) |-> used_ff == CW'(SLOTS))
      else $error("table full while use count is below slot count");

endmodule

### src/kmt_key_store.sv
`timescale 1ns / 1ps

// Key memory with per-slot valid bits and the single compare unit that
// looks at one slot per cycle during a scan.
module kmt_key_store #(
   parameter int SLOTS = 16,
   parameter int KW    = 16,
   parameter int IW    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kmt_pkg::kmt_cmd_type cmd,
   input  logic [IW-1:0]        rd_addr,
   input  logic [IW-1:0]        wr_addr,
   input  logic [KW-1:0]        key,
   output kmt_pkg::kmt_find_type find,
   output logic [IW-1:0]        hit_idx,
   output logic [IW-1:0]        free_idx
);

   logic [KW-1:0]         mem [SLOTS];
   logic [KW-1:0]         mem_q_ff;
   logic [SLOTS-1:0]      valid_ff;
   logic                  rd_vld_ff;
   logic [IW-1:0]         rd_idx_ff;
   kmt_pkg::kmt_find_type find_ff;
   logic [IW-1:0]         hit_idx_ff;
   logic [IW-1:0]         free_idx_ff;
   logic                  slot_valid;
   logic                  match;

   // The stored key is written on create; a destroy only drops the valid bit.
   always_ff @(posedge clock) begin
      if (cmd.wr_set) begin
         mem[wr_addr] <= key;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.wr_set) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (cmd.wr_clr) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_idx_ff <= rd_addr;
      end
   end

   assign slot_valid = valid_ff[rd_idx_ff];
   assign match      = slot_valid && (mem_q_ff == key);

   // Keep the first matching slot and the first free slot seen in the scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         find_ff     <= '0;
         hit_idx_ff  <= '0;
         free_idx_ff <= '0;
      end else if (cmd.clear_find) begin
         find_ff <= '0;
      end else if (rd_vld_ff) begin
         if (!find_ff.hit_found && match) begin
            find_ff.hit_found <= 1'b1;
            hit_idx_ff        <= rd_idx_ff;
         end
         if (!find_ff.free_found && !slot_valid) begin
            find_ff.free_found <= 1'b1;
            free_idx_ff        <= rd_idx_ff;
         end
      end
   end

   assign find     = find_ff;
   assign hit_idx  = hit_idx_ff;
   assign free_idx = free_idx_ff;

endmodule
